/* hdl/ps2le_pkg.sv */
package ps2le_pkg;

  localparam logic [2:0] REQ_SCAN = 3'd0;
  localparam logic [2:0] REQ_CHAR = 3'd1;
  localparam logic [2:0] REQ_TAKE = 3'd2;
  localparam logic [2:0] REQ_ECHO = 3'd3;
  localparam logic [2:0] REQ_RST  = 3'd4;

  localparam logic [7:0] KEY_LSHIFT = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT = 8'h36;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_HIGH    = 8'h80;
  localparam logic [7:0] MAX_TAKE   = 8'd128;
  localparam logic [15:0] NA_SAT    = 16'hFFFF;
  localparam int         TABLE_LEN  = 58;

  localparam logic [7:0] PLAIN_MAP [TABLE_LEN] = '{
    8'd0, 8'd27, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd48,
    8'd45, 8'd61, 8'd8, 8'd9,
    8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105, 8'd111, 8'd112,
    8'd91, 8'd93, 8'd10, 8'd0,
    8'd97, 8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd59,
    8'd39, 8'd96, 8'd0, 8'd92, 8'd122,
    8'd120, 8'd99, 8'd118, 8'd98, 8'd110, 8'd109, 8'd44, 8'd46, 8'd47, 8'd0, 8'd42,
    8'd0, 8'd32
  };

  localparam logic [7:0] SHIFT_MAP [TABLE_LEN] = '{
    8'd0, 8'd27, 8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42, 8'd40, 8'd41,
    8'd95, 8'd43, 8'd8, 8'd9,
    8'd81, 8'd87, 8'd69, 8'd82, 8'd84, 8'd89, 8'd85, 8'd73, 8'd79, 8'd80,
    8'd123, 8'd125, 8'd10, 8'd0,
    8'd65, 8'd83, 8'd68, 8'd70, 8'd71, 8'd72, 8'd74, 8'd75, 8'd76, 8'd58,
    8'd34, 8'd126, 8'd0, 8'd124, 8'd90,
    8'd88, 8'd67, 8'd86, 8'd66, 8'd78, 8'd77, 8'd60, 8'd62, 8'd63, 8'd0, 8'd42,
    8'd0, 8'd32
  };

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] scan_code;
    logic [7:0] char_in;
    logic [7:0] line_room;
  } ps2le_in_t;

  typedef struct packed {
    logic        status;
    logic        accepted;
    logic [7:0]  echo_char;
    logic        line_done;
    logic [63:0] line_chunk;
    logic [3:0]  chunk_bytes;
    logic [7:0]  line_length;
    logic        last;
    logic [15:0] nonascii_report;
    logic        overlong_warning;
    logic        queue_full_warning;
  } ps2le_out_t;

  typedef struct packed {
    logic       release_key;
    logic       shift_key;
    logic [7:0] ch;
  } scan_dec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_ECHO,
    ST_TRD,
    ST_TDATA,
    ST_TEMIT
  } ps2le_state_t;

endpackage

/* hdl/ps2le_ram.sv */
module ps2le_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ps2le_xlate.sv */
module ps2le_xlate
  import ps2le_pkg::*;
(
  input  logic [7:0] scan_code,
  input  logic       shift_held,
  output scan_dec_t  dec
);

  logic [6:0] key;

  // Bit 7 marks a release; the key number is the low seven bits.
  always_comb begin
    key = scan_code[6:0];
    dec.release_key = scan_code[7];
    dec.shift_key = ({1'b0, key} == KEY_LSHIFT) || ({1'b0, key} == KEY_RSHIFT);
    dec.ch = 8'd0;
    if (scan_code < 8'(TABLE_LEN)) begin
      dec.ch = shift_held ? SHIFT_MAP[scan_code[5:0]] : PLAIN_MAP[scan_code[5:0]];
    end
  end

endmodule

/* hdl/ps2_keyboard_line_editor_unit.sv */
// PS/2 keyboard line editor. Each input beat is one request: a set-1 scan
// code, an injected character, a line read, an echo-character read or a
// line-state reset. Characters are echoed into a ring and assembled into a
// line; CR or LF closes the line into a queue of pending lines. Scan codes,
// injected characters, resets and empty reads are answered straight from
// the idle state. Closing a non-empty line copies it byte by byte from the
// assembly memory into the pending-line memory, during which no request is
// accepted. An echo read waits in ST_ECHO for the memory read. A line read
// fetches one byte at a time (ST_TRD, then ST_TDATA) from the pending-line
// memory and emits one result beat per eight bytes, for up to 128 bytes of
// a line. A result beat that the receiver
// holds with stall blocks the input until that beat is taken.
module ps2_keyboard_line_editor_unit
  import ps2le_pkg::*;
#(
  parameter int LINE_MAX   = 128,
  parameter int LINE_SLOTS = 8,
  parameter int ECHO_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ps2le_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output ps2le_out_t out_data
);

  localparam int IW  = $clog2(LINE_MAX);
  localparam int LLW = $clog2(LINE_MAX + 1);
  localparam int HW  = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam int CW  = $clog2(LINE_SLOTS + 1);
  localparam int PAW = $clog2(LINE_SLOTS * LINE_MAX);
  localparam int EW  = $clog2(ECHO_DEPTH);

  ps2le_state_t state_r, state_nxt;

  logic           shift_r, shift_nxt;
  logic [LLW-1:0] asm_len_r, asm_len_nxt;
  logic [HW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [LLW-1:0] plen_r [LINE_SLOTS];
  logic           plen_we;
  logic [HW-1:0]  plen_slot;
  logic [EW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [15:0]    na_r, na_nxt;
  logic           ol_r, ol_nxt, qf_r, qf_nxt;

  logic [LLW-1:0] cp_rd_r, cp_rd_nxt, cp_len_r, cp_len_nxt;
  logic [HW-1:0]  cp_slot_r, cp_slot_nxt;
  logic           cp_wv_r, cp_wv_nxt;
  logic [IW-1:0]  cp_widx_r, cp_widx_nxt;

  logic [7:0]     tk_n_r, tk_n_nxt, tk_idx_r, tk_idx_nxt;
  logic [63:0]    tk_chunk_r, tk_chunk_nxt;

  logic           out_valid_r, out_valid_nxt;
  ps2le_out_t     out_data_r;
  ps2le_out_t     res;
  logic           out_load, out_free, acc;

  logic           asm_we, asm_re;
  logic [IW-1:0]  asm_waddr, asm_raddr;
  logic [7:0]     asm_wdata, asm_rdata;
  logic           pend_we, pend_re;
  logic [PAW-1:0] pend_waddr, pend_raddr;
  logic [7:0]     pend_rdata;
  logic           echo_we, echo_re;
  logic [7:0]     echo_wdata, echo_rdata;

  scan_dec_t      dec;
  logic           feed_en;
  logic [7:0]     fc;
  logic [CW:0]    tsum;
  logic [HW-1:0]  tail;
  logic [EW-1:0]  wp_inc;
  logic [7:0]     n_len, n_cut;
  logic [LLW-1:0] head_len;

  ps2le_xlate u_xlate (
    .scan_code  (in_data.scan_code),
    .shift_held (shift_r),
    .dec        (dec)
  );

  // Line being typed; copied into a pending slot when it closes.
  ps2le_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_asm_ram (
    .clk, .we(asm_we), .waddr(asm_waddr), .wdata(asm_wdata),
    .re(asm_re), .raddr(asm_raddr), .rdata(asm_rdata)
  );

  // Pending lines, one LINE_MAX-byte row per queue slot.
  ps2le_ram #(.WIDTH(8), .DEPTH(LINE_SLOTS * LINE_MAX)) u_pend_ram (
    .clk, .we(pend_we), .waddr(pend_waddr), .wdata(asm_rdata),
    .re(pend_re), .raddr(pend_raddr), .rdata(pend_rdata)
  );

  ps2le_ram #(.WIDTH(8), .DEPTH(ECHO_DEPTH)) u_echo_ram (
    .clk, .we(echo_we), .waddr(wp_r), .wdata(echo_wdata),
    .re(echo_re), .raddr(rp_r), .rdata(echo_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Queue tail slot, wrapped without a divider.
  assign tsum   = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign tail   = (tsum >= (CW+1)'(LINE_SLOTS)) ? HW'(tsum - (CW+1)'(LINE_SLOTS)) : HW'(tsum);
  assign wp_inc = (wp_r == EW'(ECHO_DEPTH - 1)) ? '0 : wp_r + 1'b1;

  // Length returned by a line read: capped at 128 and, when room is non-zero, at room minus one.
  assign head_len = plen_r[head_r];
  always_comb begin
    n_len = (32'(head_len) > 32'(MAX_TAKE)) ? MAX_TAKE : 8'(head_len);
    n_cut = n_len;
    if (in_data.line_room != 8'd0 && n_len >= in_data.line_room) begin
      n_cut = in_data.line_room - 8'd1;
    end
  end

  always_comb begin
    feed_en      = 1'b0;
    fc           = in_data.char_in;
    state_nxt    = state_r;
    shift_nxt    = shift_r;
    asm_len_nxt  = asm_len_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    na_nxt       = na_r;
    ol_nxt       = ol_r;
    qf_nxt       = qf_r;
    cp_rd_nxt    = cp_rd_r;
    cp_len_nxt   = cp_len_r;
    cp_slot_nxt  = cp_slot_r;
    cp_wv_nxt    = cp_wv_r;
    cp_widx_nxt  = cp_widx_r;
    tk_n_nxt     = tk_n_r;
    tk_idx_nxt   = tk_idx_r;
    tk_chunk_nxt = tk_chunk_r;
    plen_we      = 1'b0;
    plen_slot    = tail;
    asm_we       = 1'b0;
    asm_waddr    = IW'(asm_len_r);
    asm_re       = 1'b0;
    asm_raddr    = IW'(cp_rd_r);
    pend_we      = 1'b0;
    pend_waddr   = PAW'(cp_slot_r) * PAW'(LINE_MAX) + PAW'(cp_widx_r);
    pend_re      = 1'b0;
    pend_raddr   = PAW'(head_r) * PAW'(LINE_MAX) + PAW'(tk_idx_r);
    echo_we      = 1'b0;
    echo_re      = 1'b0;
    out_load     = 1'b0;
    res          = '0;
    res.last     = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_data.req_type)
            REQ_SCAN: begin
              out_load = 1'b1;
              if (dec.release_key) begin
                if (dec.shift_key) begin
                  shift_nxt = 1'b0;
                end else begin
                  res.status = 1'b1;
                end
              end else if (in_data.scan_code == KEY_LSHIFT ||
                           in_data.scan_code == KEY_RSHIFT) begin
                shift_nxt = 1'b1;
              end else if (dec.ch != 8'd0) begin
                feed_en = 1'b1;
                fc = dec.ch;
              end else begin
                res.status = 1'b1;
              end
            end
            REQ_CHAR: begin
              out_load = 1'b1;
              feed_en = 1'b1;
            end
            REQ_TAKE: begin
              if (cnt_r == '0) begin
                out_load = 1'b1;
                res.status = 1'b1;
              end else begin
                tk_n_nxt = n_cut;
                tk_idx_nxt = 8'd0;
                tk_chunk_nxt = '0;
                state_nxt = (n_cut == 8'd0) ? ST_TEMIT : ST_TRD;
              end
            end
            REQ_ECHO: begin
              if (rp_r == wp_r) begin
                out_load = 1'b1;
                res.status = 1'b1;
              end else begin
                echo_re = 1'b1;
                state_nxt = ST_ECHO;
              end
            end
            REQ_RST: begin
              out_load = 1'b1;
              asm_len_nxt = '0;
              head_nxt = '0;
              cnt_nxt = '0;
              ol_nxt = 1'b0;
              qf_nxt = 1'b0;
            end
            default: begin
              out_load = 1'b1;
              res.status = 1'b1;
            end
          endcase

          // Character handling shared by scan codes and injected bytes.
          if (feed_en) begin
            if (fc == CH_BS) begin
              if (asm_len_r != '0) begin
                asm_len_nxt = asm_len_r - 1'b1;
              end
            end else if (fc == CH_LF || fc == CH_CR) begin
              if (32'(cnt_r) < LINE_SLOTS) begin
                plen_we = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                if (asm_len_r != '0) begin
                  state_nxt = ST_COPY;
                  cp_rd_nxt = '0;
                  cp_len_nxt = asm_len_r;
                  cp_slot_nxt = tail;
                  cp_wv_nxt = 1'b0;
                end
              end else begin
                qf_nxt = 1'b1;
                res.queue_full_warning = 1'b1;
              end
              asm_len_nxt = '0;
              res.line_done = 1'b1;
              res.nonascii_report = na_r;
              res.overlong_warning = ol_r;
              na_nxt = '0;
              ol_nxt = 1'b0;
            end else if (fc >= CH_HIGH) begin
              if (na_r != NA_SAT) begin
                na_nxt = na_r + 16'd1;
              end
            end else if (fc >= CH_SPACE) begin
              if (32'(asm_len_r) < LINE_MAX) begin
                asm_we = 1'b1;
                asm_len_nxt = asm_len_r + 1'b1;
              end else begin
                ol_nxt = 1'b1;
              end
            end
            if (wp_inc != rp_r) begin
              echo_we = 1'b1;
              wp_nxt = wp_inc;
              res.accepted = 1'b1;
            end
          end
        end
      end
      ST_COPY: begin
        // Read one byte ahead; the write lands in the cycle after its read.
        pend_we = cp_wv_r;
        if (cp_rd_r < cp_len_r) begin
          asm_re = 1'b1;
          cp_wv_nxt = 1'b1;
          cp_widx_nxt = IW'(cp_rd_r);
          cp_rd_nxt = cp_rd_r + 1'b1;
        end else begin
          cp_wv_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          out_load = 1'b1;
          res.echo_char = echo_rdata;
          rp_nxt = (rp_r == EW'(ECHO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TRD: begin
        pend_re = 1'b1;
        state_nxt = ST_TDATA;
      end
      ST_TDATA: begin
        tk_chunk_nxt[tk_idx_r[2:0]*8 +: 8] = pend_rdata;
        tk_idx_nxt = tk_idx_r + 8'd1;
        if (tk_idx_r[2:0] == 3'd7 || tk_idx_r + 8'd1 == tk_n_r) begin
          state_nxt = ST_TEMIT;
        end else begin
          state_nxt = ST_TRD;
        end
      end
      ST_TEMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          res.line_chunk = tk_chunk_r;
          res.chunk_bytes = (tk_idx_r[2:0] == 3'd0 && tk_idx_r != 8'd0) ?
                            4'd8 : {1'b0, tk_idx_r[2:0]};
          res.line_length = tk_n_r;
          res.last = (tk_idx_r == tk_n_r);
          res.nonascii_report = na_r;
          res.overlong_warning = ol_r;
          res.queue_full_warning = qf_r;
          tk_chunk_nxt = '0;
          if (tk_idx_r == tk_n_r) begin
            head_nxt = (head_r == HW'(LINE_SLOTS - 1)) ? '0 : head_r + 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            na_nxt = '0;
            ol_nxt = 1'b0;
            qf_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_TRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The byte to store is known only once the request kind is decoded.
    asm_wdata  = fc;
    echo_wdata = fc;

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shift_r     <= 1'b0;
      asm_len_r   <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      na_r        <= '0;
      ol_r        <= 1'b0;
      qf_r        <= 1'b0;
      cp_wv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      asm_len_r   <= asm_len_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      na_r        <= na_nxt;
      ol_r        <= ol_nxt;
      qf_r        <= qf_nxt;
      cp_wv_r     <= cp_wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_rd_r    <= cp_rd_nxt;
    cp_len_r   <= cp_len_nxt;
    cp_slot_r  <= cp_slot_nxt;
    cp_widx_r  <= cp_widx_nxt;
    tk_n_r     <= tk_n_nxt;
    tk_idx_r   <= tk_idx_nxt;
    tk_chunk_r <= tk_chunk_nxt;
    if (plen_we) begin
      plen_r[plen_slot] <= asm_len_r;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  // The queue never holds more lines than it has slots.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= LINE_SLOTS)
    else $error("pending line count exceeds slots");

  // Assembled line never grows past its maximum.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(asm_len_r) <= LINE_MAX)
    else $error("assembly length exceeds maximum");

  // No new request is taken while a copy or read sequence runs.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("request accepted while busy");

  // A line read only starts with a line in the queue.
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRD) |-> (cnt_r != '0))
    else $error("line read with empty queue");

endmodule

/* tb/sv/ps2_keyboard_line_editor_unit_tb.sv */
`timescale 1ns / 1ps

// Scoreboard for the line editor. It keeps its own copy of the editor state,
// predicts the result beats of every accepted request and checks the result
// beats against them in order.
class ps2le_scoreboard;
  localparam int LMAX  = 128;
  localparam int SLOTS = 8;
  localparam int EDEPTH = 256;

  bit shift_on;
  byte unsigned asm_buf [LMAX];
  int asm_len;
  byte unsigned queued_text [SLOTS][LMAX];
  int queued_len [SLOTS];
  int q_head, q_count;
  byte unsigned echo_mem [EDEPTH];
  int echo_wr, echo_rd;
  int drop_count;
  bit overlong_seen, qfull_seen;

  ps2le_pkg::ps2le_out_t pending_beats [$];
  int mismatches;

  function new();
    shift_on = 0; asm_len = 0; q_head = 0; q_count = 0;
    echo_wr = 0; echo_rd = 0; drop_count = 0;
    overlong_seen = 0; qfull_seen = 0; mismatches = 0;
  endfunction

  function void add_char(int c, ref ps2le_pkg::ps2le_out_t r);
    int slot, nxt;
    if (c == ps2le_pkg::CH_BS) begin
      if (asm_len > 0) asm_len--;
    end else if (c == ps2le_pkg::CH_LF || c == ps2le_pkg::CH_CR) begin
      if (q_count < SLOTS) begin
        slot = (q_head + q_count) % SLOTS;
        for (int i = 0; i < asm_len; i++) queued_text[slot][i] = asm_buf[i];
        queued_len[slot] = asm_len;
        q_count++;
      end else begin
        qfull_seen = 1;
        r.queue_full_warning = 1;
      end
      asm_len = 0;
      r.line_done = 1;
      r.nonascii_report = 16'(drop_count);
      drop_count = 0;
      r.overlong_warning = overlong_seen;
      overlong_seen = 0;
    end else if (c >= ps2le_pkg::CH_HIGH) begin
      if (drop_count < ps2le_pkg::NA_SAT) drop_count++;
    end else if (c >= ps2le_pkg::CH_SPACE) begin
      if (asm_len < LMAX) asm_buf[asm_len++] = 8'(c);
      else overlong_seen = 1;
    end
    nxt = (echo_wr + 1) % EDEPTH;
    if (nxt != echo_rd) begin
      echo_mem[echo_wr] = 8'(c);
      echo_wr = nxt;
      r.accepted = 1;
    end
  endfunction

  // Notes one accepted request and queues the beats it must produce.
  function void note_request(ps2le_pkg::ps2le_in_t req);
    ps2le_pkg::ps2le_out_t r;
    int c, n, chunks, cnt;
    r = '0;
    r.last = 1;
    case (req.req_type)
      ps2le_pkg::REQ_TAKE: begin
        if (q_count == 0) begin
          r.status = 1;
          pending_beats.push_back(r);
        end else begin
          n = queued_len[q_head];
          if (req.line_room != 0 && n >= req.line_room) n = req.line_room - 1;
          if (n > ps2le_pkg::MAX_TAKE) n = ps2le_pkg::MAX_TAKE;
          chunks = (n + 7) / 8;
          if (chunks == 0) chunks = 1;
          for (int k = 0; k < chunks; k++) begin
            r = '0;
            cnt = n - k * 8;
            if (cnt > 8) cnt = 8;
            for (int b = 0; b < cnt; b++)
              r.line_chunk[8*b +: 8] = queued_text[q_head][k*8 + b];
            r.chunk_bytes = 4'(cnt);
            r.line_length = 8'(n);
            r.last = (k + 1 == chunks);
            r.nonascii_report = 16'(drop_count);
            r.overlong_warning = overlong_seen;
            r.queue_full_warning = qfull_seen;
            pending_beats.push_back(r);
          end
          q_head = (q_head + 1) % SLOTS;
          q_count--;
          drop_count = 0;
          overlong_seen = 0;
          qfull_seen = 0;
        end
        return;
      end
      ps2le_pkg::REQ_SCAN: begin
        if (req.scan_code[7]) begin
          if ({1'b0, req.scan_code[6:0]} == ps2le_pkg::KEY_LSHIFT ||
              {1'b0, req.scan_code[6:0]} == ps2le_pkg::KEY_RSHIFT) shift_on = 0;
          else r.status = 1;
        end else if (req.scan_code == ps2le_pkg::KEY_LSHIFT ||
                     req.scan_code == ps2le_pkg::KEY_RSHIFT) begin
          shift_on = 1;
        end else begin
          c = 0;
          if (req.scan_code < ps2le_pkg::TABLE_LEN)
            c = shift_on ? int'(ps2le_pkg::SHIFT_MAP[req.scan_code])
                         : int'(ps2le_pkg::PLAIN_MAP[req.scan_code]);
          if (c != 0) add_char(c, r);
          else r.status = 1;
        end
      end
      ps2le_pkg::REQ_CHAR: add_char(int'(req.char_in), r);
      ps2le_pkg::REQ_ECHO: begin
        if (echo_rd == echo_wr) r.status = 1;
        else begin
          r.echo_char = echo_mem[echo_rd];
          echo_rd = (echo_rd + 1) % EDEPTH;
        end
      end
      ps2le_pkg::REQ_RST: begin
        asm_len = 0; q_head = 0; q_count = 0;
        overlong_seen = 0; qfull_seen = 0;
      end
      default: r.status = 1;
    endcase
    pending_beats.push_back(r);
  endfunction

  // Checks one result beat against the oldest expectation.
  function void check_beat(ps2le_pkg::ps2le_out_t got);
    ps2le_pkg::ps2le_out_t want;
    if (pending_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = pending_beats.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected %h, actual %h", want, got);
    end
  endfunction
endclass

module ps2_keyboard_line_editor_unit_tb;
  import ps2le_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ps2le_in_t in_data;
  logic out_valid;
  logic out_stall;
  ps2le_out_t out_data;

  ps2le_scoreboard editor_model;

  // Idle and stall percentages for the current phase of the run.
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;

  ps2_keyboard_line_editor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Sampling happens at the rising edge: the scoreboard sees every input beat
  // and every result beat that the handshake accepts in that cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) editor_model.note_request(in_data);
      if (out_valid && !out_stall) editor_model.check_beat(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[ps2_keyboard_line_editor_unit] ERROR");
        $finish;
      end
    end
  end

  // The receiver stalls at random on the falling edge, per the current phase.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sends one request beat, with a random gap before it, and holds it until
  // the block takes it. Valid stays up across back-to-back beats.
  task automatic send_request(ps2le_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid <= 0;
    @(negedge clk);
  endtask

  function automatic ps2le_in_t make_req(logic [2:0] kind, logic [7:0] sc,
                                         logic [7:0] ch, logic [7:0] room);
    ps2le_in_t r;
    r.req_type = kind;
    r.scan_code = sc;
    r.char_in = ch;
    r.line_room = room;
    return r;
  endfunction

  // Random bits on fields the request kind does not use.
  function automatic ps2le_in_t rand_req(logic [2:0] kind);
    return make_req(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
  endfunction

  // A well-formed typing burst: keys with shifts, some injected bytes and a
  // closing CR or LF, followed sometimes by a line read.
  task automatic type_line();
    int n;
    n = $urandom_range(14, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_request(make_req(REQ_SCAN, KEY_LSHIFT, 8'($urandom_range(255)), 0));
        1: send_request(make_req(REQ_SCAN, KEY_RSHIFT | 8'h80, 8'($urandom_range(255)), 0));
        2: send_request(make_req(REQ_CHAR, 0, 8'($urandom_range(255)), 0));
        3: send_request(make_req(REQ_SCAN, 8'($urandom_range(255)), 0, 0));
        default: send_request(make_req(REQ_SCAN, 8'($urandom_range(TABLE_LEN - 1)), 0, 0));
      endcase
    end
    send_request(make_req(REQ_CHAR, 0, $urandom_range(1) ? CH_CR : CH_LF, 0));
    if ($urandom_range(2) == 0)
      send_request(make_req(REQ_TAKE, 0, 0, 8'($urandom_range(255))));
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: type_line();
        3: send_request(rand_req(REQ_TAKE));
        4: send_request(rand_req(REQ_ECHO));
        5: send_request(rand_req(3'($urandom_range(7))));
        6: send_request(rand_req(REQ_CHAR));
        default: send_request(rand_req(REQ_SCAN));
      endcase
    end
  endtask

  task automatic wait_drained();
    drop_valid();
    while (editor_model.pending_beats.size() != 0) @(negedge clk);
  endtask

  initial begin
    editor_model = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed part: empty reads, shift and release handling, unmapped keys,
    // backspace on an empty line, an over-long line, a non-ASCII drop, an
    // unknown request kind and a line-state reset.
    send_request(make_req(REQ_TAKE, 0, 0, 0));
    send_request(make_req(REQ_ECHO, 0, 0, 0));
    send_request(make_req(3'd7, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(3'd5, 0, 0, 0));
    send_request(make_req(REQ_CHAR, 0, CH_BS, 0));
    send_request(make_req(REQ_SCAN, 8'h00, 0, 0));
    send_request(make_req(REQ_SCAN, 8'hFF, 0, 0));
    send_request(make_req(REQ_SCAN, 8'h9E, 0, 0));
    send_request(make_req(REQ_SCAN, KEY_LSHIFT, 0, 0));
    send_request(make_req(REQ_SCAN, 8'h1E, 0, 0));
    send_request(make_req(REQ_SCAN, KEY_LSHIFT | 8'h80, 0, 0));
    send_request(make_req(REQ_SCAN, 8'h1E, 0, 0));
    send_request(make_req(REQ_CHAR, 0, 8'hFF, 0));
    send_request(make_req(REQ_CHAR, 0, 8'h01, 0));
    // A line longer than the maximum sets the over-long flag.
    for (int i = 0; i < 130; i++) send_request(make_req(REQ_CHAR, 0, 8'(8'h7F - i % 8), 0));
    send_request(make_req(REQ_CHAR, 0, CH_CR, 0));
    send_request(make_req(REQ_TAKE, 0, 0, 8'd0));
    // Fill the queue past its end, then read lines with small and large room.
    for (int i = 0; i < 9; i++) begin
      send_request(make_req(REQ_CHAR, 0, 8'(8'h41 + i), 0));
      send_request(make_req(REQ_SCAN, 8'h1C, 0, 0));
    end
    send_request(make_req(REQ_TAKE, 0, 0, 8'd1));
    send_request(make_req(REQ_TAKE, 0, 0, 8'd255));
    send_request(make_req(REQ_RST, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_TAKE, 0, 0, 8'd2));
    // Top up the echo ring until it reports full, then read a few back.
    for (int i = 0; i < 105; i++) send_request(make_req(REQ_CHAR, 0, 8'h09, 0));
    for (int i = 0; i < 10; i++) send_request(make_req(REQ_ECHO, 0, 0, 0));

    // Pause until every expected beat has come back.
    wait_drained();

    // Random phases with different idle and stall pressure.
    random_phase(4);
    send_idle_pct = 86;
    random_phase(4);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    random_phase(4);
    send_idle_pct = 8;
    recv_stall_pct = 8;
    random_phase(4);

    wait_drained();
    recv_stall_pct = 0;
    repeat (300) @(negedge clk);

    if (editor_model.mismatches == 0 && editor_model.pending_beats.size() == 0)
      $display("[ps2_keyboard_line_editor_unit] OK");
    else
      $display("[ps2_keyboard_line_editor_unit] ERROR");
    $finish;
  end
endmodule

/* filelist.f */
hdl/ps2le_pkg.sv
hdl/ps2le_ram.sv
hdl/ps2le_xlate.sv
hdl/ps2_keyboard_line_editor_unit.sv
tb/sv/ps2_keyboard_line_editor_unit_tb.sv
